>>> hw/rtl/abss_pkg.sv
// Shared types and constants of the abbreviation stream scanner.
package abss_pkg;

    localparam int MAX_DEPTH   = 16;
    localparam int DEPTH_W     = 5;
    localparam int STACK_N     = MAX_DEPTH + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam logic [7:0]  CONT_BIT   = 8'b10000000;
    localparam logic [7:0]  DATA_BITS  = 8'b01111111;
    localparam logic [3:0]  CODE_GROUPS = 4'd9;
    localparam logic [3:0]  WORD_GROUPS = 4'd5;
    localparam logic [3:0]  GROUP_MAX   = 4'd15;

    typedef enum logic [4:0] {
        PH_CODE = 5'b00001,
        PH_TAG  = 5'b00010,
        PH_FLAG = 5'b00100,
        PH_NAME = 5'b01000,
        PH_FORM = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        KIND_ENTRY     = 3'd0,
        KIND_ATTR      = 3'd1,
        KIND_LEVEL_END = 3'd2,
        KIND_STREAM_END = 3'd3,
        KIND_OVERFLOW  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind        kind;
        logic [62:0]  code;
        logic [31:0]  tag;
        logic         children;
        logic [31:0]  name;
        logic [31:0]  form;
        logic [15:0]  attr_count;
        logic [DEPTH_W-1:0] depth;
        logic [15:0]  level_entries;
        logic         last;
    } t_event;

    typedef struct packed {
        logic   val_a;
        logic   val_b;
        t_event ev_a;
        t_event ev_b;
    } t_push;

endpackage

>>> hw/rtl/abss_byte_if.sv
// Input channel of the scanner: one stream byte per beat.
interface abss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, data_byte, end_of_buffer, input ready);
    modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

>>> hw/rtl/abss_event_if.sv
// Output channel of the scanner: one decoded event per beat.
interface abss_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [62:0] entry_code;
    logic [31:0] entry_tag;
    logic        children_flag;
    logic [31:0] attr_name;
    logic [31:0] attr_form;
    logic [15:0] attr_count;
    logic [4:0]  nest_depth;
    logic [15:0] level_entries;
    logic        last;

    modport source (output valid, event_kind, entry_code, entry_tag, children_flag,
                    attr_name, attr_form, attr_count, nest_depth, level_entries, last,
                    input ready);
    modport sink   (input valid, event_kind, entry_code, entry_tag, children_flag,
                    attr_name, attr_form, attr_count, nest_depth, level_entries, last,
                    output ready);
endinterface

>>> hw/rtl/abss_parser.sv
// Field decoder and entry walker: turns each accepted byte into up to two events.
module abss_parser
    import abss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output t_push      o_push
);

    t_phase              r_phase, n_phase;
    logic [62:0]         r_acc, n_acc;
    logic [3:0]          r_gi, n_gi;
    logic [62:0]         r_code, n_code;
    logic [31:0]         r_tag, n_tag;
    logic                r_children, n_children;
    logic [31:0]         r_name, n_name;
    logic [15:0]         r_ac, n_ac;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [15:0]         r_cnt [STACK_N];
    logic [15:0]         n_cnt [STACK_N];

    logic [5:0]          sh;
    logic [62:0]         acc_v;
    logic                fin;
    logic [15:0]         cur_cnt;
    logic [15:0]         sat_cnt;
    logic [31:0]         form;
    t_push               push;

    always_comb begin
        sh      = 6'({2'b00, r_gi} * 6'd7);
        acc_v   = r_acc;
        if (r_gi < ((r_phase == PH_CODE) ? CODE_GROUPS : WORD_GROUPS)) begin
            acc_v = r_acc | ({56'd0, i_data_byte[6:0] & DATA_BITS[6:0]} << sh);
        end
        fin     = ((i_data_byte & CONT_BIT) == 8'd0) || i_end_of_buffer;
        cur_cnt = r_cnt[r_depth];
        sat_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + 16'd1;
        form    = acc_v[31:0];

        n_phase    = r_phase;
        n_acc      = r_acc;
        n_gi       = r_gi;
        n_code     = r_code;
        n_tag      = r_tag;
        n_children = r_children;
        n_name     = r_name;
        n_ac       = r_ac;
        n_depth    = r_depth;
        n_cnt      = r_cnt;
        push       = '0;

        if (i_accept) begin
            if (r_phase == PH_FLAG) begin
                n_children = (i_data_byte != 8'd0);
                n_phase    = PH_NAME;
            end else begin
                n_acc = acc_v;
                n_gi  = (r_gi < GROUP_MAX) ? r_gi + 4'd1 : r_gi;
                if (fin) begin
                    n_acc = '0;
                    n_gi  = '0;
                    unique case (r_phase)
                        PH_CODE: begin
                            if (acc_v == 63'd0) begin
                                push.val_a                = 1'b1;
                                push.ev_a.kind            = KIND_LEVEL_END;
                                push.ev_a.depth           = r_depth;
                                push.ev_a.level_entries   = cur_cnt;
                                if (r_depth != '0) begin
                                    n_depth = r_depth - 1'b1;
                                end else begin
                                    n_cnt[0] = '0;
                                end
                            end else begin
                                n_code  = acc_v;
                                n_ac    = '0;
                                n_phase = PH_TAG;
                            end
                        end
                        PH_TAG: begin
                            n_tag   = acc_v[31:0];
                            n_phase = PH_FLAG;
                        end
                        PH_NAME: begin
                            n_name  = acc_v[31:0];
                            n_phase = PH_FORM;
                        end
                        PH_FORM: begin
                            if (r_name == 32'd0 && form == 32'd0) begin
                                n_cnt[r_depth]           = sat_cnt;
                                push.val_a               = 1'b1;
                                push.ev_a.kind           = KIND_ENTRY;
                                push.ev_a.code           = r_code;
                                push.ev_a.tag            = r_tag;
                                push.ev_a.children       = r_children;
                                push.ev_a.attr_count     = r_ac;
                                push.ev_a.depth          = r_depth;
                                push.ev_a.level_entries  = sat_cnt;
                                if (r_children) begin
                                    if (r_depth < DEPTH_W'(MAX_DEPTH)) begin
                                        n_depth        = r_depth + 1'b1;
                                        n_cnt[n_depth] = '0;
                                    end else if (!i_end_of_buffer) begin
                                        push.val_b            = 1'b1;
                                        push.ev_b.kind        = KIND_OVERFLOW;
                                        push.ev_b.code        = r_code;
                                        push.ev_b.tag         = r_tag;
                                        push.ev_b.children    = r_children;
                                        push.ev_b.attr_count  = r_ac;
                                        push.ev_b.depth       = r_depth;
                                    end
                                end
                                n_phase = PH_CODE;
                            end else begin
                                n_ac = (r_ac == COUNT_MAX) ? r_ac : r_ac + 16'd1;
                                push.val_a            = 1'b1;
                                push.ev_a.kind        = KIND_ATTR;
                                push.ev_a.code        = r_code;
                                push.ev_a.tag         = r_tag;
                                push.ev_a.children    = r_children;
                                push.ev_a.name        = r_name;
                                push.ev_a.form        = form;
                                push.ev_a.attr_count  = n_ac;
                                push.ev_a.depth       = r_depth;
                                n_phase = PH_NAME;
                            end
                        end
                        default: begin
                            n_phase = PH_CODE;
                        end
                    endcase
                end
            end

            if (i_end_of_buffer) begin
                push.val_b      = 1'b1;
                push.ev_b       = '0;
                push.ev_b.kind  = KIND_STREAM_END;
                push.ev_b.depth = n_depth;
                n_phase    = PH_CODE;
                n_acc      = '0;
                n_gi       = '0;
                n_code     = '0;
                n_tag      = '0;
                n_children = 1'b0;
                n_name     = '0;
                n_ac       = '0;
                n_depth    = '0;
                for (int i = 0; i < STACK_N; i++) begin
                    n_cnt[i] = '0;
                end
            end

            if (push.val_b) begin
                push.ev_b.last = 1'b1;
            end else begin
                push.ev_a.last = 1'b1;
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_CODE;
            r_acc      <= '0;
            r_gi       <= '0;
            r_code     <= '0;
            r_tag      <= '0;
            r_children <= 1'b0;
            r_name     <= '0;
            r_ac       <= '0;
            r_depth    <= '0;
            for (int i = 0; i < STACK_N; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_phase    <= n_phase;
            r_acc      <= n_acc;
            r_gi       <= n_gi;
            r_code     <= n_code;
            r_tag      <= n_tag;
            r_children <= n_children;
            r_name     <= n_name;
            r_ac       <= n_ac;
            r_depth    <= n_depth;
            r_cnt      <= n_cnt;
        end
    end

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond its limit");

    a_eob_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_buffer) |=> (r_phase == PH_CODE && r_depth == '0 && r_gi == '0))
        else $error("state not cleared after the final byte");

    a_overflow_follows_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.val_b && push.ev_b.kind == KIND_OVERFLOW) |->
            (push.val_a && push.ev_a.kind == KIND_ENTRY))
        else $error("depth overflow without an entry event");

    a_only_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.val_a || push.val_b) |-> i_accept)
        else $error("event raised without an accepted beat");

endmodule

>>> hw/rtl/abss_evq.sv
// Four-entry event queue that takes up to two events a cycle and gives one a cycle while the output is ready.
module abss_evq
    import abss_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_push        i_push,
    output logic         o_room,
    abss_event_if.source o_event
);

    t_event              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]    r_wp, r_rp;
    logic [CNT_W-1:0]    r_count;
    logic [1:0]          nw;
    logic                pop;
    t_event              head;

    assign nw     = {1'b0, i_push.val_a} + {1'b0, i_push.val_b};
    assign pop    = o_event.valid && o_event.ready;
    assign o_room = (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign head   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.val_a) begin
            r_mem[r_wp] <= i_push.ev_a;
            if (i_push.val_b) begin
                r_mem[r_wp + 1'b1] <= i_push.ev_b;
            end
        end else if (i_push.val_b) begin
            r_mem[r_wp] <= i_push.ev_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + PTR_W'(nw);
            r_rp    <= r_rp + PTR_W'(pop);
            r_count <= r_count + CNT_W'(nw) - CNT_W'(pop);
        end
    end

    assign o_event.valid         = (r_count != '0);
    assign o_event.event_kind    = head.kind;
    assign o_event.entry_code    = head.code;
    assign o_event.entry_tag     = head.tag;
    assign o_event.children_flag = head.children;
    assign o_event.attr_name     = head.name;
    assign o_event.attr_form     = head.form;
    assign o_event.attr_count    = head.attr_count;
    assign o_event.nest_depth    = 5'(head.depth);
    assign o_event.level_entries = head.level_entries;
    assign o_event.last          = head.last;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (nw != 2'd0) |-> (r_count <= CNT_W'(QUEUE_DEPTH - 2)))
        else $error("events written into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && nw == 2'd0) |=> (r_count == $past(r_count) - 1'b1))
        else $error("occupancy not reduced by a lone pop");

endmodule

>>> hw/rtl/abbrev_stream_scanner.sv
// Top level of the abbreviation stream scanner: byte channel in, event channel out.
//
//   Channel   Dir  Beat carries                              Accepted when
//   i_byte    in   data_byte, end_of_buffer                  valid && ready
//   o_event   out  event_kind .. level_entries, last         valid && ready
//
// Each byte is decoded in the cycle it is accepted and its events are written
// into a four-entry event queue; the first event can leave in the cycle after.
// One byte per cycle is sustained while bytes cause at most one event each and
// the output is ready; a byte causing two events leaves a backlog, as the queue
// drains one event per cycle. Input ready drops while under two queue slots are free.
// Reset is synchronous and active low and returns the parser to the entry code.
module abbrev_stream_scanner
    import abss_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    abss_byte_if.sink    i_byte,
    abss_event_if.source o_event
);

    t_push w_push;
    logic  w_room;

    assign i_byte.ready = w_room;

    abss_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (i_byte.valid && w_room),
        .i_data_byte     (i_byte.data_byte),
        .i_end_of_buffer (i_byte.end_of_buffer),
        .o_push          (w_push)
    );

    abss_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_event (o_event)
    );

endmodule
